// ----- sv/onewire_rom_search_macros.svh -----
// Assertion macros for the 1-Wire ROM search engine.
`ifndef ONEWIRE_ROM_SEARCH_MACROS_SVH
`define ONEWIRE_ROM_SEARCH_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define OROM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define OROM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/orom_pkg.sv -----
// Types and constants shared by the 1-Wire ROM search engine.
package orom_pkg;

    localparam int RomBits = 64;
    localparam logic [6:0] FirstPassMark = 7'd65;
    localparam logic [6:0] RomBitsPos = 7'd64;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_PASS  = 2'd1,
        FUNC_BITS  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_DIR         = 3'd0,
        ST_PASS        = 3'd1,
        ST_NO_PRESENCE = 3'd2,
        ST_CONFLICT    = 3'd3,
        ST_FINISHED    = 3'd4
    } status_t;

    typedef struct packed {
        status_t              status;
        logic                 direction_bit;
        logic                 rom_ready;
        logic [RomBits-1:0]   rom_code;
        logic                 last_device;
        logic [3:0]           device_index;
    } result_t;

    // Engine state view for checks in the top level.
    typedef struct packed {
        logic       active;
        logic [6:0] bit_position;
        logic [6:0] last_discrepancy;
    } state_view_t;

endpackage

// ----- sv/orom_engine.sv -----
// Search state registers and the per-item direction decision.
module orom_engine #(
    parameter int MAX_DEVICES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  orom_pkg::func_t      func,
    input  logic                 presence,
    input  logic                 bit_true,
    input  logic                 bit_complement,
    output logic                 has_result,
    output orom_pkg::result_t    result,
    output orom_pkg::state_view_t state_view
);
    import orom_pkg::*;

    localparam int CountBits = $clog2(MAX_DEVICES + 1);
    localparam int CountW = (CountBits > 4) ? CountBits : 4;

    logic [6:0]         last_disc_reg, last_disc_next;
    logic [6:0]         new_disc_reg, new_disc_next;
    logic [6:0]         bit_pos_reg, bit_pos_next;
    logic [RomBits-1:0] prev_rom_reg, prev_rom_next;
    logic [RomBits-1:0] cur_rom_reg, cur_rom_next;
    logic [CountW-1:0]  found_reg, found_next;
    logic               active_reg, active_next;

    logic [6:0] pos;
    logic [5:0] idx;
    logic       dir;

    assign idx = bit_pos_reg[5:0];
    assign pos = bit_pos_reg + 7'd1;

    always_comb
    begin
        last_disc_next = last_disc_reg;
        new_disc_next  = new_disc_reg;
        bit_pos_next   = bit_pos_reg;
        prev_rom_next  = prev_rom_reg;
        cur_rom_next   = cur_rom_reg;
        found_next     = found_reg;
        active_next    = active_reg;
        has_result     = 1'b0;
        result         = '0;
        result.status  = ST_FINISHED;
        dir            = 1'b0;

        unique case (func)
            FUNC_START:
            begin
                last_disc_next = FirstPassMark;
                new_disc_next  = '0;
                bit_pos_next   = RomBitsPos;
                prev_rom_next  = '0;
                cur_rom_next   = '0;
                found_next     = '0;
                active_next    = 1'b1;
            end
            FUNC_PASS:
            begin
                has_result = 1'b1;
                if (!active_reg)
                begin
                    result.status = ST_FINISHED;
                end
                else if (last_disc_reg == 7'd0 || found_reg >= CountW'(MAX_DEVICES))
                begin
                    active_next   = 1'b0;
                    bit_pos_next  = RomBitsPos;
                    result.status = ST_FINISHED;
                end
                else if (!presence)
                begin
                    active_next   = 1'b0;
                    bit_pos_next  = RomBitsPos;
                    result.status = ST_NO_PRESENCE;
                end
                else
                begin
                    bit_pos_next  = '0;
                    cur_rom_next  = '0;
                    new_disc_next = '0;
                    result.status = ST_PASS;
                end
            end
            FUNC_BITS:
            begin
                has_result = 1'b1;
                if (!active_reg || bit_pos_reg >= RomBitsPos)
                begin
                    result.status = ST_FINISHED;
                end
                else if (bit_true && bit_complement)
                begin
                    active_next   = 1'b0;
                    bit_pos_next  = RomBitsPos;
                    result.status = ST_CONFLICT;
                end
                else
                begin
                    // both zero: devices disagree here, a fork
                    if (!bit_true && !bit_complement)
                    begin
                        if (pos < last_disc_reg)
                        begin
                            dir = prev_rom_reg[idx];
                            if (!dir)
                            begin
                                new_disc_next = pos;
                            end
                        end
                        else if (pos == last_disc_reg)
                        begin
                            dir = 1'b1;
                        end
                        else
                        begin
                            dir = 1'b0;
                            new_disc_next = pos;
                        end
                    end
                    else
                    begin
                        dir = bit_true;
                    end
                    if (dir)
                    begin
                        cur_rom_next[idx] = 1'b1;
                    end
                    bit_pos_next         = pos;
                    result.status        = ST_DIR;
                    result.direction_bit = dir;
                    if (pos == RomBitsPos)
                    begin
                        prev_rom_next       = cur_rom_next;
                        last_disc_next      = new_disc_next;
                        found_next          = found_reg + CountW'(1);
                        result.rom_ready    = 1'b1;
                        result.rom_code     = cur_rom_next;
                        result.last_device  = (new_disc_next == 7'd0);
                        result.device_index = found_reg[3:0];
                    end
                end
            end
            FUNC_NONE:
            begin
                has_result = 1'b0;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_disc_reg <= FirstPassMark;
            new_disc_reg  <= '0;
            bit_pos_reg   <= '0;
            prev_rom_reg  <= '0;
            cur_rom_reg   <= '0;
            found_reg     <= '0;
            active_reg    <= 1'b0;
        end
        else if (fire)
        begin
            last_disc_reg <= last_disc_next;
            new_disc_reg  <= new_disc_next;
            bit_pos_reg   <= bit_pos_next;
            prev_rom_reg  <= prev_rom_next;
            cur_rom_reg   <= cur_rom_next;
            found_reg     <= found_next;
            active_reg    <= active_next;
        end
    end

    assign state_view.active           = active_reg;
    assign state_view.bit_position     = bit_pos_reg;
    assign state_view.last_discrepancy = last_disc_reg;

endmodule

// ----- sv/onewire_rom_search.sv -----
// An accepted item waits in the input register until it advances into the result register, which drives m_tvalid.
// Throughput: one item per cycle while m_tready holds no result back; the input register
// and the result register run in a single pass through the decision logic of orom_engine.
// Start and unused selector items make no result but still take one slot.
// Reset (rst_n low, asynchronous): both stages empty, search idle, last fork 65.
module onewire_rom_search #(
    parameter int MAX_DEVICES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // presence, bit_true, bit_complement, zero pad
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // direction_bit, rom_code[63:0], device_index[3:0], pad
    output logic [3:0]  m_tuser,   // status[2:0], rom_ready
    output logic        m_tlast    // last_device
);
    import orom_pkg::*;

    // input register stage
    logic    in_valid_reg;
    func_t   in_func_reg;
    logic    in_presence_reg;
    logic    in_true_reg;
    logic    in_compl_reg;

    // result register stage
    logic    out_valid_reg;
    result_t out_result_reg;

    logic        advance;
    logic        has_result;
    result_t     result;
    state_view_t state_view;

    // terms for the checks at the end
    logic        rom_out;
    logic        state_ok;
    logic        start_taken;

    // Items that make no result never wait on the output side.
    assign advance  = in_valid_reg && (!has_result || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg     <= func_t'(s_tuser);
            in_presence_reg <= s_tdata[0];
            in_true_reg     <= s_tdata[1];
            in_compl_reg    <= s_tdata[2];
        end
    end

    orom_engine #(
        .MAX_DEVICES(MAX_DEVICES)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .func          (in_func_reg),
        .presence      (in_presence_reg),
        .bit_true      (in_true_reg),
        .bit_complement(in_compl_reg),
        .has_result    (has_result),
        .result        (result),
        .state_view    (state_view)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg.device_index, out_result_reg.rom_code,
                       out_result_reg.direction_bit};
    assign m_tuser  = {out_result_reg.rom_ready, out_result_reg.status};
    assign m_tlast  = out_result_reg.last_device;

    assign rom_out     = out_valid_reg && out_result_reg.rom_ready;
    assign state_ok    = (state_view.bit_position <= RomBitsPos) &&
                         (state_view.last_discrepancy <= FirstPassMark);
    assign start_taken = advance && (in_func_reg == FUNC_START);

    `include "onewire_rom_search_macros.svh"

    // a completed ROM only comes with a direction result
    `OROM_ASSERT(a_rom_with_dir, !rom_out || out_result_reg.status == ST_DIR, "rom without dir")
    // pass position and fork marker stay in their ranges
    `OROM_ASSERT(a_state_range, state_ok, "search state out of range")
    // a start item always leaves the search running
    `OROM_ASSERT_NEXT(a_start_active, start_taken, state_view.active, "start left search idle")

endmodule

// ----- tb/orom_checker.sv -----
`timescale 1ns / 100ps
// Checker for onewire_rom_search: predicts each result of the ROM search and compares.
module orom_checker #(
    parameter int DEVICE_LIMIT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [3:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          roms_seen
);
    import orom_pkg::*;

    // Search state mirrored from the block
    logic [6:0]  last_fork;
    logic [6:0]  newest_fork;
    logic [6:0]  bits_done;
    logic [63:0] prior_rom;
    logic [63:0] building_rom;
    int          devices_found;
    logic        searching;

    result_t expected_results[$];

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        fail_count++;
    endtask

    // One input item through the search rules; returns 1 when it yields a result.
    function automatic bit search_step(input func_t f, input logic [7:0] d,
                                       output result_t r);
        logic [6:0] pos;
        logic       dir;
        r = '0;
        r.status = ST_FINISHED;
        case (f)
            FUNC_START:
            begin
                last_fork     = FirstPassMark;
                newest_fork   = '0;
                bits_done     = RomBitsPos;
                prior_rom     = '0;
                building_rom  = '0;
                devices_found = 0;
                searching     = 1'b1;
                return 1'b0;
            end
            FUNC_PASS:
            begin
                if (!searching)
                    return 1'b1;
                if (last_fork == 7'd0 || devices_found >= DEVICE_LIMIT)
                begin
                    searching = 1'b0;
                    bits_done = RomBitsPos;
                    return 1'b1;
                end
                if (!d[0])
                begin
                    searching = 1'b0;
                    bits_done = RomBitsPos;
                    r.status  = ST_NO_PRESENCE;
                    return 1'b1;
                end
                bits_done    = '0;
                building_rom = '0;
                newest_fork  = '0;
                r.status     = ST_PASS;
                return 1'b1;
            end
            FUNC_BITS:
            begin
                if (!searching || bits_done >= RomBitsPos)
                    return 1'b1;
                if (d[1] && d[2])
                begin
                    searching = 1'b0;
                    bits_done = RomBitsPos;
                    r.status  = ST_CONFLICT;
                    return 1'b1;
                end
                pos = bits_done + 7'd1;
                if (!d[1] && !d[2])
                begin
                    // fork: follow the last ROM below the branch point, take 1 at it and 0 above it
                    if (pos < last_fork)
                    begin
                        dir = prior_rom[pos - 7'd1];
                        if (!dir)
                            newest_fork = pos;
                    end
                    else if (pos == last_fork)
                        dir = 1'b1;
                    else
                    begin
                        dir = 1'b0;
                        newest_fork = pos;
                    end
                end
                else
                    dir = d[1];
                if (dir)
                    building_rom[pos - 7'd1] = 1'b1;
                bits_done       = pos;
                r.status        = ST_DIR;
                r.direction_bit = dir;
                if (pos == RomBitsPos)
                begin
                    r.rom_ready    = 1'b1;
                    r.rom_code     = building_rom;
                    r.last_device  = (newest_fork == 7'd0);
                    r.device_index = 4'(devices_found);
                    prior_rom      = building_rom;
                    last_fork      = newest_fork;
                    devices_found++;
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            last_fork     = FirstPassMark;
            newest_fork   = '0;
            bits_done     = '0;
            prior_rom     = '0;
            building_rom  = '0;
            devices_found = 0;
            searching     = 1'b0;
            expected_results.delete();
            fail_count    = 0;
            pending       = 0;
            results_seen  = 0;
            roms_seen     = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (search_step(func_t'(s_tuser), s_tdata, want))
                    expected_results.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.status        = status_t'(m_tuser[2:0]);
                got.rom_ready     = m_tuser[3];
                got.direction_bit = m_tdata[0];
                got.rom_code      = m_tdata[64:1];
                got.device_index  = m_tdata[68:65];
                got.last_device   = m_tlast;
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("result item with no expectation waiting");
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.status, want.status));
                    if (got.direction_bit != want.direction_bit)
                        report_mismatch($sformatf("direction_bit %0b, want %0b",
                                                  got.direction_bit, want.direction_bit));
                    if (got.rom_ready != want.rom_ready)
                        report_mismatch($sformatf("rom_ready %0b, want %0b",
                                                  got.rom_ready, want.rom_ready));
                    if (got.rom_code != want.rom_code)
                        report_mismatch($sformatf("rom_code %h, want %h",
                                                  got.rom_code, want.rom_code));
                    if (got.last_device != want.last_device)
                        report_mismatch($sformatf("last_device %0b, want %0b",
                                                  got.last_device, want.last_device));
                    if (got.device_index != want.device_index)
                        report_mismatch($sformatf("device_index %0d, want %0d",
                                                  got.device_index, want.device_index));
                    if (want.rom_ready)
                        roms_seen++;
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for onewire_rom_search: stimulus, flow control and verdict.
module tb_top;
    import orom_pkg::*;

    // Low device limit so that the stop-after-N-devices rule is reached within
    // a few full passes.
    localparam int DEVICE_LIMIT = 2;
    localparam int ITEM_TARGET  = 650;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // presence, bit_true, bit_complement, zero pad
    logic [1:0]  s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // direction_bit, rom_code[63:0], device_index[3:0], pad
    logic [3:0]  m_tuser;   // status[2:0], rom_ready
    logic        m_tlast;   // last_device

    int fail_count;
    int pending;
    int results_seen;
    int roms_seen;

    int items_sent;     // items other than the unused selector
    int searches_run;
    int burst_left;
    int cycle_count;

    onewire_rom_search #(
        .MAX_DEVICES (DEVICE_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    orom_checker #(
        .DEVICE_LIMIT (DEVICE_LIMIT)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .roms_seen    (roms_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offer one item at the falling edge and hold it until it is taken.
    // Valid stays high across a burst; between bursts it drops for a gap,
    // so valid never gets two updates in one time step.
    task automatic send_item(input func_t f, input logic presence,
                             input logic bit_true, input logic bit_comp);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {5'b0, bit_comp, bit_true, presence};
        do
            @(posedge clk);
        while (!s_tready);
        if (f != FUNC_NONE)
            items_sent++;
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            // mostly short bursts, sometimes long stretches with no gaps
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
        end
    endtask

    // One bit pair: a fork (both zero) with fork_pct percent, a rare conflict
    // (both one) with conflict_pm per mille, otherwise a plain 0 or 1.
    task automatic send_pair(input int fork_pct, input int conflict_pm);
        logic b;
        b = 1'($urandom_range(1));
        if ($urandom_range(999) < conflict_pm)
            send_item(FUNC_BITS, 1'($urandom_range(1)), 1'b1, 1'b1);
        else if ($urandom_range(99) < fork_pct)
            send_item(FUNC_BITS, 1'($urandom_range(1)), 1'b0, 1'b0);
        else
            send_item(FUNC_BITS, 1'($urandom_range(1)), b, ~b);
    endtask

    // Well-formed search: start, then passes of a pass-start and 64 pairs.
    // A few passes are cut short or run without presence.
    task automatic run_search();
        int passes;
        int pairs;
        int fork_pct;
        int conflict_pm;
        int sel;
        passes = $urandom_range(1, DEVICE_LIMIT + 1);
        searches_run++;
        send_item(FUNC_START, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
        repeat (passes)
        begin
            send_item(FUNC_PASS, ($urandom_range(15) != 0), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
            sel = $urandom_range(2);
            // no forks at all makes this the last device
            fork_pct    = (sel == 0) ? 0 : (sel == 1) ? 6 : 35;
            conflict_pm = ($urandom_range(5) == 0) ? 25 : 0;
            pairs       = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : 64;
            repeat (pairs) send_pair(fork_pct, conflict_pm);
        end
    endtask

    // Receiver flow control: modes of random span - always ready, coin flip,
    // one in four, and occasional long stalls.
    initial
    begin
        int mode;
        int span;
        int stall_left;
        int tick;
        m_tready   = 1'b0;
        stall_left = 0;
        tick       = 0;
        forever
        begin
            mode = $urandom_range(3);
            span = $urandom_range(64, 256);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(1));
                    2: m_tready <= (tick % 4 == 0);
                    default:
                    begin
                        if (stall_left > 0)
                        begin
                            stall_left--;
                            m_tready <= 1'b0;
                        end
                        else
                        begin
                            m_tready <= 1'b1;
                            if ($urandom_range(7) == 0)
                                stall_left = $urandom_range(1, 12);
                        end
                    end
                endcase
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = FUNC_START;
        items_sent   = 0;
        searches_run = 0;
        burst_left   = $urandom_range(1, 12);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: idle cases, unused selector, missing presence, conflict,
        // bit pair outside a pass, restart in the middle of a pass.
        send_item(FUNC_PASS,  1'b1, 1'b0, 1'b0);   // pass start while idle
        send_item(FUNC_BITS,  1'b0, 1'b1, 1'b0);   // bit pair while idle
        send_item(FUNC_NONE,  1'b1, 1'b1, 1'b1);   // ignored
        send_item(FUNC_START, 1'b0, 1'b0, 1'b0);
        send_item(FUNC_BITS,  1'b0, 1'b0, 1'b1);   // no pass open yet
        send_item(FUNC_PASS,  1'b0, 1'b1, 1'b1);   // nobody answered reset
        send_item(FUNC_PASS,  1'b1, 1'b0, 1'b0);   // search already over
        send_item(FUNC_START, 1'b1, 1'b1, 1'b1);
        send_item(FUNC_PASS,  1'b1, 1'b0, 1'b0);
        send_item(FUNC_BITS,  1'b0, 1'b0, 1'b1);
        send_item(FUNC_BITS,  1'b1, 1'b1, 1'b0);
        send_item(FUNC_BITS,  1'b0, 1'b0, 1'b0);   // fork on the first pass
        send_item(FUNC_BITS,  1'b1, 1'b1, 1'b1);   // conflict, search aborts
        send_item(FUNC_BITS,  1'b0, 1'b0, 1'b0);   // after the abort
        send_item(FUNC_START, 1'b0, 1'b0, 1'b0);
        send_item(FUNC_PASS,  1'b1, 1'b1, 1'b1);
        send_item(FUNC_BITS,  1'b1, 1'b0, 1'b0);
        send_item(FUNC_START, 1'b0, 1'b1, 1'b0);   // restart mid-pass
        send_item(FUNC_PASS,  1'b1, 1'b0, 1'b1);
        send_item(FUNC_BITS,  1'b0, 1'b0, 1'b0);

        // Random: mostly complete searches, some noise items in between
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(3) != 0)
                run_search();
            else
                repeat ($urandom_range(1, 6))
                    send_item(func_t'($urandom_range(3)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items over %0d searches with noise between them.",
                 items_sent, searches_run);
        $display("Compared %0d results, %0d of them completed ROM codes.",
                 results_seen, roms_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/orom_pkg.sv
sv/orom_engine.sv
sv/onewire_rom_search.sv
tb/orom_checker.sv
tb/tb_top.sv
